>>> hw/rtl/range_histogram_emd_compare_core_macros.svh
// Assertion macros shared by the range histogram compare RTL.
`ifndef RANGE_HISTOGRAM_EMD_COMPARE_CORE_MACROS_SVH
`define RANGE_HISTOGRAM_EMD_COMPARE_CORE_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define RHE_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rhe invariant violated");

// Same-cycle implication.
`define RHE_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rhe implication violated");

`endif

>>> hw/rtl/rhe_pkg.sv
// Shared constants and types of the range histogram compare block.
package rhe_pkg;
	localparam int DIST_W   = 17;
	localparam int FRAC_W   = 16;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_DROP  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;
endpackage

>>> hw/rtl/rhe_in_if.sv
// Sample channel: valid/ready handshake carrying one range sample word.
interface rhe_in_if #(
	parameter int RANGE_WIDTH = 24
) ();
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic signed [RANGE_WIDTH-1:0] range;
	logic                          last;

	modport source (output valid, mode, range, last, input ready);
	modport sink (input valid, mode, range, last, output ready);
endinterface

>>> hw/rtl/rhe_out_if.sv
// Result channel: valid/ready handshake carrying one scan summary word.
interface rhe_out_if
	import rhe_pkg::*;
#(
	parameter int RANGE_WIDTH = 24,
	parameter int COUNT_WIDTH = 13
) ();
	logic                          valid;
	logic                          ready;
	logic                          scan_id;
	logic [COUNT_WIDTH-1:0]        points;
	logic signed [RANGE_WIDTH-1:0] low_range;
	logic signed [RANGE_WIDTH-1:0] high_range;
	logic [DIST_W-1:0]             distance;
	logic                          distance_valid;
	logic [STATUS_W-1:0]           status;

	modport source (output valid, scan_id, points, low_range, high_range, distance,
		distance_valid, status, input ready);
	modport sink (input valid, scan_id, points, low_range, high_range, distance,
		distance_valid, status, output ready);
endinterface

>>> hw/rtl/rhe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rhe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/range_histogram_emd_compare_core.sv
// Range histogram compare core: stores two scans, bins them, reports 1D EMD.
// Samples of scan A (mode 0) and scan B (mode 1) are taken one per cycle while the
// core is idle and written to per-scan sample RAMs; min and max track on the fly.
// A sample marked last starts the histogram pass for its scan: the scan's bin RAM is
// cleared, then every stored sample goes through sample read, bit-serial quotient and
// bin read-modify-write, with the quotient skipped when the sample falls on the low
// edge or the scan span is zero. After scan B the distance pass follows (cumulative
// sums through both bin RAMs, then a 17-step restoring divider). New samples are
// held off during the pass; a finished result waits in the output register while
// the next scan streams in.
`include "range_histogram_emd_compare_core_macros.svh"
module range_histogram_emd_compare_core
	import rhe_pkg::*;
#(
	parameter int BINS        = 30,
	parameter int MAX_POINTS  = 4096,
	parameter int RANGE_WIDTH = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	rhe_in_if.sink   samples,
	rhe_out_if.source results
);
	localparam int RW   = RANGE_WIDTH;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int PAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int BAW  = $clog2(BINS);
	localparam int PW   = 2 * CW;
	localparam int NUMW = PW + BAW;
	localparam int DVW  = NUMW + FRAC_W + 1;
	localparam int BNW  = RW + BAW;
	localparam int WW   = (DVW > BNW) ? DVW : BNW;
	localparam int SCW  = $clog2(DIST_W);
	localparam logic [BAW:0] BINS_V = (BAW + 1)'(BINS);
	localparam logic [CW-1:0] MAXP_V = CW'(MAX_POINTS);
	localparam logic signed [RW-1:0] RMAX = {1'b0, {(RW - 1){1'b1}}};
	localparam logic signed [RW-1:0] RMIN = {1'b1, {(RW - 1){1'b0}}};

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_CLR  = 15'b000000000000010,
		S_PRD  = 15'b000000000000100,
		S_MUL  = 15'b000000000001000,
		S_BDIV = 15'b000000000010000,
		S_BRD  = 15'b000000000100000,
		S_BWR  = 15'b000000001000000,
		S_ERD  = 15'b000000010000000,
		S_EACC = 15'b000000100000000,
		S_EMUL = 15'b000001000000000,
		S_ESUM = 15'b000010000000000,
		S_DEN1 = 15'b000100000000000,
		S_DEN2 = 15'b001000000000000,
		S_EDIV = 15'b010000000000000,
		S_FIN  = 15'b100000000000000
	} state_t;

	state_t state_q;
	logic   s_q;
	logic [CW-1:0]        cnt_q [2];
	logic signed [RW-1:0] lo_q [2];
	logic signed [RW-1:0] hi_q [2];
	logic                 ovf_q [2];
	logic [CW-1:0]        na_q;
	logic [RW-1:0]        span_q;
	logic [CW-1:0]        k_q;
	logic [BAW-1:0]       i_q;
	logic [BAW-1:0]       bin_q;
	logic [WW-1:0]        rem_q;
	logic [WW-1:0]        dv_q;
	logic [DIST_W-1:0]    quo_q;
	logic [SCW-1:0]       st_q;
	logic [CW-1:0]        ca_q;
	logic [CW-1:0]        cb_q;
	logic [PW-1:0]        x_q;
	logic [PW-1:0]        y_q;
	logic [NUMW-1:0]      num_q;
	logic [PW-1:0]        den_q;
	logic [DIST_W-1:0]    dist_q;
	logic                 ov_q;

	logic                 acc;
	logic                 m;
	logic [CW-1:0]        mcnt;
	logic signed [RW-1:0] mlo;
	logic signed [RW-1:0] mhi;
	logic                 full;
	logic [CW-1:0]        ccnt;
	logic signed [RW-1:0] clo;
	logic signed [RW-1:0] chi;
	logic                 covf;
	logic [RW:0]          span_w;
	logic signed [RW-1:0] pa_rd;
	logic signed [RW-1:0] pb_rd;
	logic signed [RW-1:0] pr;
	logic [RW:0]          d_w;
	logic [RW-1:0]        d;
	logic [WW-1:0]        nmul;
	logic                 ge;
	logic [WW-1:0]        rem_n;
	logic [DIST_W-1:0]    quo_n;
	logic [CW-1:0]        ba_rd;
	logic [CW-1:0]        bb_rd;
	logic                 bin_we;
	logic [BAW-1:0]       bin_waddr;
	logic [CW-1:0]        bin_wdata;
	logic [BAW-1:0]       bin_raddr;
	logic [CW-1:0]        nb;
	logic [CW-1:0]        fa;
	logic [CW-1:0]        fb;
	logic [CW-1:0]        ga;
	logic [CW-1:0]        gb;
	logic [WW-1:0]        denb;
	logic                 fin_load;
	state_t               after_bins;
	status_t              st_code;

	assign samples.ready = (state_q == S_IDLE);
	assign acc  = samples.valid && samples.ready;
	assign m    = samples.mode;
	assign mcnt = m ? cnt_q[1] : cnt_q[0];
	assign mlo  = m ? lo_q[1] : lo_q[0];
	assign mhi  = m ? hi_q[1] : hi_q[0];
	assign full = (mcnt == MAXP_V);

	assign ccnt = s_q ? cnt_q[1] : cnt_q[0];
	assign clo  = s_q ? lo_q[1] : lo_q[0];
	assign chi  = s_q ? hi_q[1] : hi_q[0];
	assign covf = s_q ? ovf_q[1] : ovf_q[0];

	assign span_w = {chi[RW-1], chi} - {clo[RW-1], clo};
	assign pr     = s_q ? pb_rd : pa_rd;
	assign d_w    = {pr[RW-1], pr} - {clo[RW-1], clo};
	assign d      = d_w[RW-1:0];
	assign nmul   = WW'(d) * WW'(BINS_V) - WW'(1);

	assign ge    = (rem_q >= dv_q);
	assign rem_n = ge ? (rem_q - dv_q) : rem_q;
	assign quo_n = {quo_q[DIST_W-2:0], ge};

	assign nb = cnt_q[1];
	assign ga = (na_q != '0) ? na_q : CW'(1);
	assign gb = (nb != '0) ? nb : CW'(1);
	assign fa = (na_q != '0) ? gb : '0;
	assign fb = (nb != '0) ? ga : '0;
	assign denb = WW'(den_q) * WW'(BINS_V);

	assign after_bins = s_q ? S_ERD : S_FIN;
	assign fin_load   = (state_q == S_FIN) && (!ov_q || results.ready);
	assign st_code    = covf ? STATUS_DROP :
		((s_q && na_q == '0) ? STATUS_EMPTY : STATUS_OK);

	assign bin_we    = (state_q == S_CLR) || (state_q == S_BWR);
	assign bin_waddr = (state_q == S_CLR) ? i_q : bin_q;
	assign bin_wdata = (state_q == S_CLR) ? '0 : ((s_q ? bb_rd : ba_rd) + CW'(1));
	assign bin_raddr = (state_q == S_ERD) ? i_q : bin_q;

	rhe_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_pts_a (
		.clk   (clk),
		.we    (acc && !full && !m),
		.waddr (mcnt[PAW-1:0]),
		.wdata (samples.range),
		.raddr (k_q[PAW-1:0]),
		.rdata (pa_rd)
	);

	rhe_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_pts_b (
		.clk   (clk),
		.we    (acc && !full && m),
		.waddr (mcnt[PAW-1:0]),
		.wdata (samples.range),
		.raddr (k_q[PAW-1:0]),
		.rdata (pb_rd)
	);

	rhe_ram #(.WIDTH(CW), .DEPTH(BINS)) u_bins_a (
		.clk   (clk),
		.we    (bin_we && !s_q),
		.waddr (bin_waddr),
		.wdata (bin_wdata),
		.raddr (bin_raddr),
		.rdata (ba_rd)
	);

	rhe_ram #(.WIDTH(CW), .DEPTH(BINS)) u_bins_b (
		.clk   (clk),
		.we    (bin_we && s_q),
		.waddr (bin_waddr),
		.wdata (bin_wdata),
		.raddr (bin_raddr),
		.rdata (bb_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			s_q     <= 1'b0;
			na_q    <= '0;
			ov_q    <= 1'b0;
			for (int sc = 0; sc < 2; sc++) begin
				cnt_q[sc] <= '0;
				lo_q[sc]  <= RMAX;
				hi_q[sc]  <= RMIN;
				ovf_q[sc] <= 1'b0;
			end
		end else begin
			for (int sc = 0; sc < 2; sc++) begin
				if (acc && m == 1'(sc)) begin
					if (full) begin
						ovf_q[sc] <= 1'b1;
					end else begin
						cnt_q[sc] <= mcnt + CW'(1);
						if (samples.range < mlo) lo_q[sc] <= samples.range;
						if (samples.range > mhi) hi_q[sc] <= samples.range;
					end
				end
				if (fin_load && s_q == 1'(sc)) begin
					cnt_q[sc] <= '0;
					lo_q[sc]  <= RMAX;
					hi_q[sc]  <= RMIN;
					ovf_q[sc] <= 1'b0;
				end
			end

			if (fin_load) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (acc && samples.last) begin
						s_q     <= m;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					if (i_q == BAW'(BINS - 1)) begin
						state_q <= (ccnt == '0) ? after_bins : S_PRD;
					end
				end
				S_PRD: state_q <= S_MUL;
				S_MUL: begin
					state_q <= (span_q == '0 || d == '0) ? S_BRD : S_BDIV;
				end
				S_BDIV: if (st_q == '0) state_q <= S_BRD;
				S_BRD: state_q <= S_BWR;
				S_BWR: state_q <= (k_q + CW'(1) == ccnt) ? after_bins : S_PRD;
				S_ERD: state_q <= S_EACC;
				S_EACC: state_q <= S_EMUL;
				S_EMUL: state_q <= S_ESUM;
				S_ESUM: state_q <= (i_q == BAW'(BINS - 1)) ? S_DEN1 : S_ERD;
				S_DEN1: state_q <= S_DEN2;
				S_DEN2: state_q <= S_EDIV;
				S_EDIV: if (st_q == '0) state_q <= S_FIN;
				S_FIN: begin
					if (fin_load) begin
						if (!s_q) na_q <= cnt_q[0];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			k_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: i_q <= '0;
				S_CLR: begin
					k_q <= '0;
					i_q <= (i_q == BAW'(BINS - 1)) ? '0 : i_q + BAW'(1);
				end
				S_BWR: k_q <= k_q + CW'(1);
				S_ESUM: i_q <= i_q + BAW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_CLR: begin
				span_q <= span_w[RW-1:0];
				ca_q   <= '0;
				cb_q   <= '0;
				num_q  <= '0;
			end
			S_MUL: begin
				bin_q <= '0;
				rem_q <= nmul;
				dv_q  <= WW'(span_q) << (BAW - 1);
				quo_q <= '0;
				st_q  <= SCW'(BAW - 1);
			end
			S_BDIV: begin
				rem_q <= rem_n;
				dv_q  <= dv_q >> 1;
				quo_q <= quo_n;
				st_q  <= st_q - SCW'(1);
				if (st_q == '0) bin_q <= quo_n[BAW-1:0];
			end
			S_EACC: begin
				// A bins are unwritten until the first scan A ends
				ca_q <= ca_q + ((na_q != '0) ? ba_rd : '0);
				cb_q <= cb_q + bb_rd;
			end
			S_EMUL: begin
				x_q <= PW'(ca_q) * PW'(fa);
				y_q <= PW'(cb_q) * PW'(fb);
			end
			S_ESUM: begin
				num_q <= num_q + NUMW'((x_q > y_q) ? (x_q - y_q) : (y_q - x_q));
			end
			S_DEN1: den_q <= PW'(ga) * PW'(gb);
			S_DEN2: begin
				rem_q <= (WW'(num_q) << FRAC_W) + (denb >> 1);
				dv_q  <= denb << FRAC_W;
				quo_q <= '0;
				st_q  <= SCW'(DIST_W - 1);
			end
			S_EDIV: begin
				rem_q <= rem_n;
				dv_q  <= dv_q >> 1;
				quo_q <= quo_n;
				st_q  <= st_q - SCW'(1);
				if (st_q == '0) dist_q <= quo_n;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			results.scan_id        <= s_q;
			results.points         <= ccnt;
			results.low_range      <= clo;
			results.high_range     <= chi;
			results.distance       <= s_q ? dist_q : '0;
			results.distance_valid <= s_q;
			results.status         <= st_code;
		end
	end

	assign results.valid = ov_q;

	`RHE_ASSERT_HOLDS(a_cnt_bound, cnt_q[0] <= MAXP_V && cnt_q[1] <= MAXP_V)
	`RHE_ASSERT_IMPL(a_scan_a_no_dist, results.valid && !results.scan_id, results.distance == '0 && !results.distance_valid)
	`RHE_ASSERT_IMPL(a_bin_in_range, state_q == S_BWR, {1'b0, bin_q} < BINS_V)
	`RHE_ASSERT_IMPL(a_emd_only_b, state_q == S_ERD || state_q == S_EDIV, s_q)
endmodule
